@@ hw/rtl/max_pool_2d_stream_core_assert.svh @@
// ----------------------------------------------------------------------------
// Max pool assertion macros
// Shorthand for the concurrent checks of the max pool stream core.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_CORE_ASSERT_SVH
`define MAX_POOL_2D_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define MP2D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define MP2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define MP2D_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mp2d_pkg.sv @@
// ----------------------------------------------------------------------------
// Max pool package
// Shared constants, register indexes and control types of the max pool core.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Default build parameters
  localparam int DEF_MAX_SIDE     = 256;
  localparam int DEF_MAX_CHANNELS = 256;
  localparam int DEF_POOL         = 2;
  localparam int DEF_STRIDE       = 2;
  localparam int DEF_SAMPLE_BITS  = 16;

  // Configuration port
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIDE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] IMAGE_SIDE_RESET    = 9'd256;
  localparam logic [CFG_DATA_W-1:0] CHANNEL_COUNT_RESET = 9'd1;

  // Result field widths
  localparam int CHANNEL_FIELD_W = 8;
  localparam int POS_FIELD_W     = 7;

  // Window position flags for one sample
  typedef struct packed {
    logic in_win;      // sample lies inside a whole window
    logic col_first;   // first column of its window
    logic col_last;    // last column of its window
    logic row_first;   // first row of its window
    logic row_last;    // last row of its window
    logic last_plane;  // window is the last one of the plane
    logic last_frame;  // ... and the plane is the last channel
  } win_ctl_t;

endpackage

@@ hw/rtl/mp2d_ram.sv @@
// ----------------------------------------------------------------------------
// Max pool line RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mp2d_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/mp2d_addr_gen.sv @@
// ----------------------------------------------------------------------------
// Max pool position tracker
// Raster counters for column, row and channel, split into window index and
// phase, and the window flags of the sample at the head of the stream.
// ----------------------------------------------------------------------------
module mp2d_addr_gen import mp2d_pkg::*; #(
  parameter  int MAX_SIDE     = DEF_MAX_SIDE,
  parameter  int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter  int POOL         = DEF_POOL,
  parameter  int STRIDE       = DEF_STRIDE,
  localparam int WIN_W  = (((MAX_SIDE - 1) / STRIDE + 1) > 1) ?
                          $clog2((MAX_SIDE - 1) / STRIDE + 1) : 1,
  localparam int CHP_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [CFG_DATA_W-1:0] cfg_side,
  input  logic [CFG_DATA_W-1:0] cfg_chans,
  output win_ctl_t              ctl,
  output logic [WIN_W-1:0]      win_col,
  output logic [WIN_W-1:0]      win_row,
  output logic [CHP_W-1:0]      chan
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);
  localparam int PH_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int EW     = SIDE_W + 5;
  localparam int CEW    = CHN_W + 1;

  logic [SIDE_W-1:0] side_eff;
  logic [CHN_W-1:0]  chans_eff;

  logic [SIDE_W-1:0] col_pos_r, col_pos_nxt, row_pos_r, row_pos_nxt;
  logic [PH_W-1:0]   col_ph_r, col_ph_nxt, row_ph_r, row_ph_nxt;
  logic [WIN_W-1:0]  col_win_r, col_win_nxt, row_win_r, row_win_nxt;
  logic [CHP_W-1:0]  chan_r, chan_nxt;

  logic [EW-1:0]  col_base, row_base;
  logic [CEW-1:0] chan_inc;
  logic           col_ok, row_ok, col_end, row_end;
  logic           col_wrap, row_wrap, chan_wrap;

  // Clamp the configured side and channel count to their legal ranges
  always_comb begin
    if (cfg_side < CFG_DATA_W'(2)) begin
      side_eff = SIDE_W'(2);
    end else if (32'(cfg_side) > MAX_SIDE) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(cfg_side);
    end
    if (cfg_chans == '0) begin
      chans_eff = CHN_W'(1);
    end else if (32'(cfg_chans) > MAX_CHANNELS) begin
      chans_eff = CHN_W'(MAX_CHANNELS);
    end else begin
      chans_eff = CHN_W'(cfg_chans);
    end
  end

  // Window membership: the window starting at base fits when base + POOL <= side
  assign col_base = EW'(col_pos_r) - EW'(col_ph_r);
  assign row_base = EW'(row_pos_r) - EW'(row_ph_r);
  assign col_ok   = (32'(col_ph_r) < POOL) && (col_base + EW'(POOL) <= EW'(side_eff));
  assign row_ok   = (32'(row_ph_r) < POOL) && (row_base + EW'(POOL) <= EW'(side_eff));
  assign col_end  = (col_base + EW'(STRIDE + POOL)) > EW'(side_eff);
  assign row_end  = (row_base + EW'(STRIDE + POOL)) > EW'(side_eff);

  assign chan_inc = CEW'(chan_r) + CEW'(1);

  // Flags of the current sample
  always_comb begin
    ctl.in_win     = col_ok && row_ok;
    ctl.col_first  = (col_ph_r == '0);
    ctl.col_last   = (col_ph_r == PH_W'(POOL - 1));
    ctl.row_first  = (row_ph_r == '0);
    ctl.row_last   = (row_ph_r == PH_W'(POOL - 1));
    ctl.last_plane = col_end && row_end;
    ctl.last_frame = col_end && row_end && (chan_inc == CEW'(chans_eff));
  end

  assign win_col = col_win_r;
  assign win_row = row_win_r;
  assign chan    = chan_r;

  // Advance the raster position on each transfer
  assign col_wrap  = (EW'(col_pos_r) + EW'(1)) >= EW'(side_eff);
  assign row_wrap  = (EW'(row_pos_r) + EW'(1)) >= EW'(side_eff);
  assign chan_wrap = chan_inc >= CEW'(chans_eff);

  always_comb begin
    col_pos_nxt = col_pos_r;
    col_ph_nxt  = col_ph_r;
    col_win_nxt = col_win_r;
    row_pos_nxt = row_pos_r;
    row_ph_nxt  = row_ph_r;
    row_win_nxt = row_win_r;
    chan_nxt    = chan_r;
    if (advance) begin
      if (col_wrap) begin
        col_pos_nxt = '0;
        col_ph_nxt  = '0;
        col_win_nxt = '0;
        if (row_wrap) begin
          row_pos_nxt = '0;
          row_ph_nxt  = '0;
          row_win_nxt = '0;
          chan_nxt    = chan_wrap ? '0 : CHP_W'(chan_inc);
        end else begin
          row_pos_nxt = row_pos_r + SIDE_W'(1);
          if (row_ph_r == PH_W'(STRIDE - 1)) begin
            row_ph_nxt  = '0;
            row_win_nxt = row_win_r + WIN_W'(1);
          end else begin
            row_ph_nxt  = row_ph_r + PH_W'(1);
          end
        end
      end else begin
        col_pos_nxt = col_pos_r + SIDE_W'(1);
        if (col_ph_r == PH_W'(STRIDE - 1)) begin
          col_ph_nxt  = '0;
          col_win_nxt = col_win_r + WIN_W'(1);
        end else begin
          col_ph_nxt  = col_ph_r + PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      col_ph_r  <= '0;
      col_win_r <= '0;
      row_pos_r <= '0;
      row_ph_r  <= '0;
      row_win_r <= '0;
      chan_r    <= '0;
    end else begin
      col_pos_r <= col_pos_nxt;
      col_ph_r  <= col_ph_nxt;
      col_win_r <= col_win_nxt;
      row_pos_r <= row_pos_nxt;
      row_ph_r  <= row_ph_nxt;
      row_win_r <= row_win_nxt;
      chan_r    <= chan_nxt;
    end
  end

endmodule

@@ hw/rtl/mp2d_reduce.sv @@
// ----------------------------------------------------------------------------
// Max pool reduction stage
// Holds one sample with its window flags, keeps the running row maximum,
// merges it with the column partial maximum in the line RAM and loads the
// result register.
// ----------------------------------------------------------------------------
module mp2d_reduce import mp2d_pkg::*; #(
  parameter  int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter  int MAX_SIDE     = DEF_MAX_SIDE,
  parameter  int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter  int POOL         = DEF_POOL,
  parameter  int STRIDE       = DEF_STRIDE,
  localparam int WIN_W  = (((MAX_SIDE - 1) / STRIDE + 1) > 1) ?
                          $clog2((MAX_SIDE - 1) / STRIDE + 1) : 1,
  localparam int CHP_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  win_ctl_t                      in_ctl,
  input  logic [WIN_W-1:0]              in_win_col,
  input  logic [WIN_W-1:0]              in_win_row,
  input  logic [CHP_W-1:0]              in_chan,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_max_value,
  output logic [CHANNEL_FIELD_W-1:0]    out_channel_index,
  output logic [POS_FIELD_W-1:0]        out_row,
  output logic [POS_FIELD_W-1:0]        out_col,
  output logic                          out_last_of_plane,
  output logic                          out_last_of_frame
);

  localparam int LINE_DEPTH = (MAX_SIDE - POOL) / STRIDE + 1;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Stage register
  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  win_ctl_t                      s1_ctl_r;
  logic [WIN_W-1:0]              s1_col_r, s1_row_r;
  logic [CHP_W-1:0]              s1_chan_r;

  logic signed [SAMPLE_BITS-1:0] run_r;
  logic signed [SAMPLE_BITS-1:0] run_start, run_new, merged, line_rd;
  logic [SAMPLE_BITS-1:0]        ram_rd_data;
  logic                          s1_emit, s1_go, line_wr;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_max_r;
  logic [CHANNEL_FIELD_W-1:0]    out_chan_r;
  logic [POS_FIELD_W-1:0]        out_row_r, out_col_r;
  logic                          out_lp_r, out_lf_r;

  // Advance the stage unless its result would overwrite a waiting one
  assign s1_emit  = s1_ctl_r.in_win && s1_ctl_r.col_last && s1_ctl_r.row_last;
  assign s1_go    = s1_valid_r && (!s1_emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_ctl_r    <= in_ctl;
      s1_col_r    <= in_win_col;
      s1_row_r    <= in_win_row;
      s1_chan_r   <= in_chan;
    end
  end

  // Running maximum along the window row, then merge with the line store
  assign line_rd   = $signed(ram_rd_data);
  assign run_start = s1_ctl_r.col_first ? MOST_NEG : run_r;
  assign run_new   = (s1_sample_r > run_start) ? s1_sample_r : run_start;
  assign merged    = (s1_ctl_r.row_first || (run_new > line_rd)) ? run_new : line_rd;
  assign line_wr   = s1_go && s1_ctl_r.in_win && s1_ctl_r.col_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= MOST_NEG;
    end else if (s1_go && s1_ctl_r.in_win) begin
      run_r <= run_new;
    end
  end

  // Column partial maxima, read as the sample enters the stage
  mp2d_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (s1_col_r[ADDR_W-1:0]),
    .wr_data (merged),
    .rd_en   (in_fire),
    .rd_addr (in_win_col[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Result register: load on a finished window, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_max_r  <= merged;
      out_chan_r <= CHANNEL_FIELD_W'(s1_chan_r);
      out_row_r  <= POS_FIELD_W'(s1_row_r);
      out_col_r  <= POS_FIELD_W'(s1_col_r);
      out_lp_r   <= s1_ctl_r.last_plane;
      out_lf_r   <= s1_ctl_r.last_frame;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_max_value     = out_max_r;
  assign out_channel_index = out_chan_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_plane = out_lp_r;
  assign out_last_of_frame = out_lf_r;

endmodule

@@ hw/rtl/max_pool_2d_stream_core.sv @@
// ----------------------------------------------------------------------------
// Max pool 2-D stream core
// Streaming POOL x POOL max pooling at a stride of STRIDE over square planes.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel (valid/ready) in channel-major, row-major
// raster order, one sample per transfer. For every whole window one result
// leaves on the out_ channel with its channel, output row and column, and
// flags for the last window of a plane and of the frame. Samples in rows or
// columns past the last whole window are taken and dropped.
// cfg_we/cfg_index/cfg_data write image_side (index 0) and channel_count
// (index 1); write them only while no transfer is in flight.
// Throughput: one sample per cycle unless a result stalls on out_ready; a new
// sample is taken in the same cycle an earlier result is still waiting. A
// window's last sample is registered in the reduction stage with the line RAM
// read, then the result register loads from that stage once it may advance.
// The line RAM holds one partial maximum per output column; its single read
// and single write port set the one-sample-per-cycle rate.
// When out_ready is low with a result waiting, the core holds it and stops
// taking samples once the next window result is ready to leave.
// Reset clears positions and the running maximum and sets image_side to 256
// and channel_count to 1; the line RAM is not cleared.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_core import mp2d_pkg::*; #(
  parameter int MAX_SIDE     = DEF_MAX_SIDE,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int POOL         = DEF_POOL,
  parameter int STRIDE       = DEF_STRIDE,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_max_value,
  output logic [CHANNEL_FIELD_W-1:0]    out_channel_index,
  output logic [POS_FIELD_W-1:0]        out_row,
  output logic [POS_FIELD_W-1:0]        out_col,
  output logic                          out_last_of_plane,
  output logic                          out_last_of_frame,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int WIN_W = (((MAX_SIDE - 1) / STRIDE + 1) > 1) ?
                         $clog2((MAX_SIDE - 1) / STRIDE + 1) : 1;
  localparam int CHP_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [CFG_DATA_W-1:0] side_r, side_nxt, chans_r, chans_nxt;
  logic                  in_fire;
  win_ctl_t              head_ctl;
  logic [WIN_W-1:0]      head_col, head_row;
  logic [CHP_W-1:0]      head_chan;

  // Configuration register decode
  always_comb begin
    side_nxt  = side_r;
    chans_nxt = chans_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_SIDE:    side_nxt  = cfg_data;
        CFG_CHANNEL_COUNT: chans_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= IMAGE_SIDE_RESET;
      chans_r <= CHANNEL_COUNT_RESET;
    end else begin
      side_r  <= side_nxt;
      chans_r <= chans_nxt;
    end
  end

  assign in_fire = in_valid && in_ready;

  mp2d_addr_gen #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_CHANNELS (MAX_CHANNELS),
    .POOL         (POOL),
    .STRIDE       (STRIDE)
  ) u_addr_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_fire),
    .cfg_side  (side_r),
    .cfg_chans (chans_r),
    .ctl       (head_ctl),
    .win_col   (head_col),
    .win_row   (head_row),
    .chan      (head_chan)
  );

  mp2d_reduce #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_SIDE     (MAX_SIDE),
    .MAX_CHANNELS (MAX_CHANNELS),
    .POOL         (POOL),
    .STRIDE       (STRIDE)
  ) u_reduce (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_ready          (in_ready),
    .in_sample         (in_sample_value),
    .in_ctl            (head_ctl),
    .in_win_col        (head_col),
    .in_win_row        (head_row),
    .in_chan           (head_chan),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_max_value     (out_max_value),
    .out_channel_index (out_channel_index),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_plane (out_last_of_plane),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

@@ hw/rtl/mp2d_checker.sv @@
// ----------------------------------------------------------------------------
// Max pool port checker
// Concurrent checks on the result channel of the max pool stream core.
// ----------------------------------------------------------------------------
`include "max_pool_2d_stream_core_assert.svh"

module mp2d_checker import mp2d_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_max_value,
  input logic [CHANNEL_FIELD_W-1:0]    out_channel_index,
  input logic [POS_FIELD_W-1:0]        out_row,
  input logic [POS_FIELD_W-1:0]        out_col,
  input logic                          out_last_of_plane,
  input logic                          out_last_of_frame
);

  // Hold a stalled result
  `MP2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_max_value) && $stable(out_channel_index) && $stable(out_row) && $stable(out_col), "stalled result changed")

  // No result right after reset
  `MP2D_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid, "result valid after reset")

  // Frame end is always a plane end
  `MP2D_ASSERT_SAME(a_frame_in_plane, out_valid && out_last_of_frame, out_last_of_plane, "frame end without plane end")

  // Last window of a square plane sits on the diagonal
  `MP2D_ASSERT_SAME(a_plane_end_diag, out_valid && out_last_of_plane, out_row == out_col, "plane end off the diagonal")

endmodule

bind max_pool_2d_stream_core mp2d_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_max_value     (out_max_value),
  .out_channel_index (out_channel_index),
  .out_row           (out_row),
  .out_col           (out_col),
  .out_last_of_plane (out_last_of_plane),
  .out_last_of_frame (out_last_of_frame)
);
